### rtl/tcrt_pkg.sv
// Package: constants, types and helpers for the TCP control retransmit timer.
`timescale 1ns / 1ps
`default_nettype none
package tcrt_pkg;
  localparam int SOCKETS   = 64;
  localparam int MAX_BATCH = 16;
  localparam int SIDX_W    = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;
  localparam int SCNT_W    = $clog2(SOCKETS + 1);
  localparam int BATCH_W   = $clog2(MAX_BATCH + 1);

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_ARM    = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_SYN    = 2'd1;
  localparam logic [1:0] KIND_SYNACK = 2'd2;

  localparam logic [1:0] EV_SEND    = 2'd0;
  localparam logic [1:0] EV_FAILED  = 2'd1;
  localparam logic [1:0] EV_CLOSE   = 2'd2;

  localparam logic [7:0] FLAG_FIN = 8'h01;
  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_RST = 8'h04;
  localparam logic [7:0] FLAG_ACK = 8'h10;

  localparam logic [1:0] REG_RETRY_LIMIT = 2'd0;
  localparam logic [1:0] REG_TIMEOUT     = 2'd1;
  localparam logic [1:0] REG_BATCH_LIMIT = 2'd2;

  typedef struct packed {
    logic [SIDX_W-1:0] out_sock;
    logic [1:0]        event_res;
    logic [31:0]       seq_num;
    logic [31:0]       ack_num;
    logic [7:0]        tcp_flags;
  } result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  retries;
    logic [31:0] deadline;
  } meta_t;

  typedef struct packed {
    logic [31:0] tx_seq;
    logic [31:0] rx_seq;
  } seqs_t;

  function automatic logic [7:0] retx_flags(input logic [1:0] k);
    logic [7:0] f;
    if (k == KIND_SYN) f = FLAG_SYN;
    else if (k == KIND_SYNACK) f = FLAG_SYN | FLAG_ACK;
    else f = FLAG_FIN | FLAG_ACK;
    return f;
  endfunction
endpackage
`default_nettype wire

### rtl/tcrt_if.sv
// Interfaces: input channel and result channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface tcrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [5:0]  sock_index;
  logic [1:0]  kind;
  logic [31:0] tx_seq;
  logic [31:0] rx_seq;
  modport source (output valid, action, sock_index, kind, tx_seq, rx_seq, input ready);
  modport sink (input valid, action, sock_index, kind, tx_seq, rx_seq, output ready);
endinterface

interface tcrt_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  out_sock;
  logic [1:0]  event_res;
  logic [31:0] seq_num;
  logic [31:0] ack_num;
  logic [7:0]  tcp_flags;
  logic        last;
  modport source (output valid, out_sock, event_res, seq_num, ack_num, tcp_flags, last,
                  input ready);
  modport sink (input valid, out_sock, event_res, seq_num, ack_num, tcp_flags, last,
                output ready);
endinterface
`default_nettype wire

### rtl/tcp_control_retransmit_timer.sv
// Top level: per-socket retransmit timer with a sequential socket scanner.
//
//   channel  | dir | handshake          | carries
//   in_ch    | in  | valid/ready        | action, sock_index, kind, tx_seq, rx_seq
//   out_ch   | out | valid/ready        | out_sock, event_res, seq_num, ack_num, flags, last
//   apb      | in  | psel/penable/pready| retry_limit, timeout_ticks, batch_limit
//
// Arm and cancel are handled in S_IDLE. A tick scans the sockets in turn (memory read in S_RD,
// then evaluate in S_EV through the one compare/add unit) until all are scanned or the batch
// limit is reached; S_EV and S_FIN wait while the result register waits on out_ch.ready.
// One result is held back until the next is found so the last flag is known.
// Reset (rst, synchronous) clears armed bits, time and the registers; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module tcp_control_retransmit_timer (
  input  wire logic        clk,
  input  wire logic        rst,
  tcrt_in_if.sink          in_ch,
  tcrt_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EV   = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;
  logic [7:0]  retry_limit;
  logic [15:0] timeout_ticks;
  logic [4:0]  batch_limit;
  logic [31:0] now_ticks;
  logic [tcrt_pkg::SOCKETS-1:0] armed;
  logic [tcrt_pkg::SCNT_W-1:0]  scan;
  logic [tcrt_pkg::BATCH_W-1:0] handled;
  logic [tcrt_pkg::BATCH_W-1:0] limit;

  tcrt_pkg::meta_t meta_mem [tcrt_pkg::SOCKETS];
  tcrt_pkg::seqs_t seqs_mem [tcrt_pkg::SOCKETS];
  tcrt_pkg::meta_t meta_rd;
  tcrt_pkg::seqs_t seqs_rd;

  tcrt_pkg::result_t pend;
  logic              pend_v;
  tcrt_pkg::result_t res;
  logic              out_valid;
  logic              out_last;

  // APB
  logic [1:0] reg_sel;
  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  always_comb begin
    unique case (reg_sel)
      tcrt_pkg::REG_RETRY_LIMIT: prdata = {24'd0, retry_limit};
      tcrt_pkg::REG_TIMEOUT:     prdata = {16'd0, timeout_ticks};
      tcrt_pkg::REG_BATCH_LIMIT: prdata = {27'd0, batch_limit};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit   <= 8'd3;
      timeout_ticks <= 16'd1000;
      batch_limit   <= 5'd16;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        tcrt_pkg::REG_RETRY_LIMIT: retry_limit   <= pwdata[7:0];
        tcrt_pkg::REG_TIMEOUT:     timeout_ticks <= pwdata[15:0];
        tcrt_pkg::REG_BATCH_LIMIT: batch_limit   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // shared compare/add unit
  logic [31:0] diff;
  logic [31:0] next_deadline;
  logic [tcrt_pkg::SIDX_W-1:0] sidx;
  logic        expired;
  logic        in_acc;
  logic        out_free;
  logic        in_range;
  logic        emits;
  logic        stall;
  logic        out_load;

  assign sidx          = scan[tcrt_pkg::SIDX_W-1:0];
  assign diff          = now_ticks - meta_rd.deadline;
  assign next_deadline = now_ticks + {16'd0, timeout_ticks};
  assign expired       = armed[sidx] && (diff != 32'd0) && !diff[31];
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign out_free      = !out_valid || out_ch.ready;
  assign in_range      = (32'(in_ch.sock_index) < tcrt_pkg::SOCKETS);
  assign emits         = expired && (meta_rd.kind != tcrt_pkg::KIND_NONE);
  assign stall         = emits && pend_v && !out_free;
  assign in_ch.ready   = (state == S_IDLE);
  assign out_load      = (state == S_EV && emits && pend_v && !stall) ||
                         (state == S_FIN && pend_v && out_free);

  always_comb begin
    res.out_sock = sidx;
    if (meta_rd.retries != 8'd0) begin
      res.event_res = tcrt_pkg::EV_SEND;
      res.seq_num   = seqs_rd.tx_seq - 32'd1;
      res.ack_num   = seqs_rd.rx_seq;
      res.tcp_flags = tcrt_pkg::retx_flags(meta_rd.kind);
    end else if (meta_rd.kind == tcrt_pkg::KIND_SYN) begin
      res.event_res = tcrt_pkg::EV_FAILED;
      res.seq_num   = 32'd0;
      res.ack_num   = 32'd0;
      res.tcp_flags = 8'd0;
    end else begin
      res.event_res = tcrt_pkg::EV_CLOSE;
      res.seq_num   = seqs_rd.tx_seq;
      res.ack_num   = seqs_rd.rx_seq;
      res.tcp_flags = tcrt_pkg::FLAG_RST | tcrt_pkg::FLAG_ACK;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc && in_ch.action == tcrt_pkg::ACT_ARM && in_range) begin
      meta_mem[in_ch.sock_index[tcrt_pkg::SIDX_W-1:0]] <=
        '{kind: in_ch.kind, retries: retry_limit, deadline: next_deadline};
      seqs_mem[in_ch.sock_index[tcrt_pkg::SIDX_W-1:0]] <=
        '{tx_seq: in_ch.tx_seq, rx_seq: in_ch.rx_seq};
    end else if (state == S_EV && emits && !stall && meta_rd.retries != 8'd0) begin
      meta_mem[sidx] <= '{kind: meta_rd.kind, retries: meta_rd.retries - 8'd1,
                          deadline: next_deadline};
    end
    if (state == S_RD) begin
      meta_rd <= meta_mem[sidx];
      seqs_rd <= seqs_mem[sidx];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      now_ticks <= 32'd0;
      armed     <= '0;
      scan      <= '0;
      handled   <= '0;
      limit     <= '0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && !out_load) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            priority if (in_ch.action == tcrt_pkg::ACT_ARM) begin
              if (in_range) armed[in_ch.sock_index[tcrt_pkg::SIDX_W-1:0]] <= 1'b1;
            end else if (in_ch.action == tcrt_pkg::ACT_CANCEL) begin
              if (in_range) armed[in_ch.sock_index[tcrt_pkg::SIDX_W-1:0]] <= 1'b0;
            end else if (in_ch.action == tcrt_pkg::ACT_TICK) begin
              now_ticks <= now_ticks + 32'd1;
              scan      <= '0;
              handled   <= '0;
              pend_v    <= 1'b0;
              limit     <= (32'(batch_limit) > tcrt_pkg::MAX_BATCH) ?
                           tcrt_pkg::BATCH_W'(tcrt_pkg::MAX_BATCH) :
                           tcrt_pkg::BATCH_W'(batch_limit);
              state     <= S_RD;
            end else begin
            end
          end
        end
        S_RD: begin
          if (32'(scan) >= tcrt_pkg::SOCKETS || handled >= limit) state <= S_FIN;
          else state <= S_EV;
        end
        S_EV: begin
          if (!stall) begin
            if (expired) begin
              handled <= handled + 1'b1;
              if (!emits || meta_rd.retries == 8'd0) armed[sidx] <= 1'b0;
              if (emits) begin
                // flush the held result now that another follows
                if (pend_v) begin
                  out_valid           <= 1'b1;
                  out_last            <= 1'b0;
                  out_ch.out_sock     <= 6'(pend.out_sock);
                  out_ch.event_res    <= pend.event_res;
                  out_ch.seq_num      <= pend.seq_num;
                  out_ch.ack_num      <= pend.ack_num;
                  out_ch.tcp_flags    <= pend.tcp_flags;
                end
                pend   <= res;
                pend_v <= 1'b1;
              end
            end
            scan  <= scan + 1'b1;
            state <= S_RD;
          end
        end
        S_FIN: begin
          if (!pend_v) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid        <= 1'b1;
            out_last         <= 1'b1;
            out_ch.out_sock  <= 6'(pend.out_sock);
            out_ch.event_res <= pend.event_res;
            out_ch.seq_num   <= pend.seq_num;
            out_ch.ack_num   <= pend.ack_num;
            out_ch.tcp_flags <= pend.tcp_flags;
            pend_v           <= 1'b0;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.last  = out_last;
endmodule
`default_nettype wire

### rtl/tcrt_checker.sv
// Checker: port-level assertions for the retransmit timer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tcrt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_action,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_seq
);
  // a tick starts a scan: input must close
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_action == tcrt_pkg::ACT_TICK |=> !in_ready)
    else $error("ready still high after tick");

  // arm and cancel finish at once
  a_arm_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_action == tcrt_pkg::ACT_ARM ||
    in_action == tcrt_pkg::ACT_CANCEL) |=> in_ready)
    else $error("ready dropped after arm or cancel");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_seq))
    else $error("stalled result changed");
endmodule

bind tcp_control_retransmit_timer tcrt_checker u_tcrt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_seq   (out_ch.seq_num)
);
`default_nettype wire

### tb/sv/tb_tcp_control_retransmit_timer.sv
// Testbench for the TCP control retransmit timer: directed table, random phases, self-check.
`timescale 1ns / 1ps
module tb_tcp_control_retransmit_timer;
  import tcrt_pkg::*;

  localparam logic [1:0] KIND_FIN    = 2'd3;
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam int         DRAIN_CYC   = 2 * SOCKETS + 20;
  localparam int         CYCLE_LIMIT = 600000;

  typedef struct {
    logic [5:0]  sock;
    logic [1:0]  ev;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
    logic        last;
  } timer_event_t;

  typedef struct {
    logic [1:0]   act;
    logic [5:0]   idx;
    logic [1:0]   knd;
    logic [31:0]  tx;
    logic [31:0]  rx;
    bit           typed;
    timer_event_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tcrt_in_if  in_ch ();
  tcrt_out_if out_ch ();

  tcp_control_retransmit_timer u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  m_retry_limit;
  logic [15:0] m_timeout;
  logic [4:0]  m_batch;
  logic [31:0] m_now;
  logic        m_armed [SOCKETS];
  logic [1:0]  m_kind [SOCKETS];
  logic [7:0]  m_retries [SOCKETS];
  logic [31:0] m_deadline [SOCKETS];
  logic [31:0] m_tx [SOCKETS];
  logic [31:0] m_rx [SOCKETS];

  timer_event_t pending_events[$];
  int errors = 0;
  int burst_left = 0;
  int cycles = 0;
  int hold_cnt = 0;
  logic hold_start = 1'b0;
  int stall_mode = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic predict_timer(input logic [1:0] act, input logic [5:0] idx,
                               input logic [1:0] knd, input logic [31:0] tx,
                               input logic [31:0] rx);
    timer_event_t evs[$];
    timer_event_t e;
    int lim;
    int handled;
    logic [31:0] diff;
    handled = 0;
    case (act)
      ACT_ARM: begin
        m_armed[idx] = 1'b1;
        m_kind[idx] = knd;
        m_retries[idx] = m_retry_limit;
        m_deadline[idx] = m_now + 32'(m_timeout);
        m_tx[idx] = tx;
        m_rx[idx] = rx;
      end
      ACT_CANCEL: begin
        m_armed[idx] = 1'b0;
        m_kind[idx] = KIND_NONE;
        m_retries[idx] = '0;
      end
      ACT_TICK: begin
        m_now = m_now + 1;
        lim = (m_batch > MAX_BATCH) ? MAX_BATCH : int'(m_batch);
        for (int s = 0; s < SOCKETS && handled < lim; s++) begin
          diff = m_now - m_deadline[s];
          if (!m_armed[s] || diff == 0 || diff[31]) continue;
          handled++;
          if (m_kind[s] == KIND_NONE) begin
            // silent disarm, still counts against the batch
            m_armed[s] = 1'b0;
            m_retries[s] = '0;
            continue;
          end
          e.sock = 6'(s);
          e.last = 1'b0;
          if (m_retries[s] != 0) begin
            e.ev = EV_SEND;
            e.seq = m_tx[s] - 1;
            e.ack = m_rx[s];
            e.flags = (m_kind[s] == KIND_SYN) ? FLAG_SYN :
                      (m_kind[s] == KIND_SYNACK) ? (FLAG_SYN | FLAG_ACK) :
                      (FLAG_FIN | FLAG_ACK);
            m_retries[s] = m_retries[s] - 1;
            m_deadline[s] = m_now + 32'(m_timeout);
          end else begin
            if (m_kind[s] == KIND_SYN) begin
              e.ev = EV_FAILED;
              e.seq = '0;
              e.ack = '0;
              e.flags = '0;
            end else begin
              e.ev = EV_CLOSE;
              e.seq = m_tx[s];
              e.ack = m_rx[s];
              e.flags = FLAG_RST | FLAG_ACK;
            end
            m_armed[s] = 1'b0;
            m_kind[s] = KIND_NONE;
            m_retries[s] = '0;
          end
          evs.push_back(e);
        end
        if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
    foreach (evs[i]) pending_events.push_back(evs[i]);
  endtask

  task automatic reg_write(input logic [1:0] reg_idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_idx)
      REG_RETRY_LIMIT: m_retry_limit = value[7:0];
      REG_TIMEOUT:     m_timeout = value[15:0];
      default:         m_batch = value[4:0];
    endcase
  endtask

  task automatic configure(input int retry, input int tmo, input int batch);
    reg_write(REG_RETRY_LIMIT, 32'(retry));
    reg_write(REG_TIMEOUT, 32'(tmo));
    reg_write(REG_BATCH_LIMIT, 32'(batch));
  endtask

  // returns at a rising edge with the transaction taken
  task automatic send_item(input logic [1:0] act, input logic [5:0] idx,
                           input logic [1:0] knd, input logic [31:0] tx,
                           input logic [31:0] rx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.sock_index <= idx;
    in_ch.kind <= knd;
    in_ch.tx_seq <= tx;
    in_ch.rx_seq <= rx;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    predict_timer(act, idx, knd, tx, rx);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    // ticks that end in silent disarms leave no result to wait on
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic random_item();
    int r;
    logic [1:0] knd;
    r = $urandom_range(0, 99);
    knd = ($urandom_range(0, 15) == 0) ? KIND_NONE : 2'($urandom_range(1, 3));
    if (r < 42)
      send_item(ACT_ARM, 6'($urandom), knd, $urandom, $urandom);
    else if (r < 55)
      send_item(ACT_CANCEL, 6'($urandom), 2'($urandom), $urandom, $urandom);
    else if (r < 96)
      send_item(ACT_TICK, 6'($urandom), 2'($urandom), $urandom, $urandom);
    else
      send_item(ACT_UNKNOWN, 6'($urandom), 2'($urandom), $urandom, $urandom);
  endtask

  // receiver stall pattern, with a long hold-off counted here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
    if (hold_start) hold_cnt <= 400;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    if (rst || hold_cnt != 0 || hold_start) out_ch.ready <= 1'b0;
    else case (stall_mode)
      0, 1: out_ch.ready <= 1'b1;
      2: out_ch.ready <= ($urandom_range(0, 1) == 1);
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // check each result transaction before the edge that takes it
  always @(negedge clk) begin
    timer_event_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_events.size() == 0) begin
        report("unexpected result for socket", 32'(out_ch.out_sock), 32'hx);
      end else begin
        e = pending_events.pop_front();
        if (out_ch.out_sock !== e.sock) report("out_sock", 32'(out_ch.out_sock), 32'(e.sock));
        if (out_ch.event_res !== e.ev) report("event_res", 32'(out_ch.event_res), 32'(e.ev));
        if (out_ch.seq_num !== e.seq) report("seq_num", out_ch.seq_num, e.seq);
        if (out_ch.ack_num !== e.ack) report("ack_num", out_ch.ack_num, e.ack);
        if (out_ch.tcp_flags !== e.flags) report("tcp_flags", 32'(out_ch.tcp_flags), 32'(e.flags));
        if (out_ch.last !== e.last) report("last", 32'(out_ch.last), 32'(e.last));
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  stim_row_t rows[$];

  task automatic add_row(input logic [1:0] act, input logic [5:0] idx, input logic [1:0] knd,
                         input logic [31:0] tx, input logic [31:0] rx);
    stim_row_t r;
    r.act = act; r.idx = idx; r.knd = knd; r.tx = tx; r.rx = rx; r.typed = 1'b0;
    rows.push_back(r);
  endtask

  initial begin
    int retry_set[7] = '{1, 0, 255, 2, 3, 4, 0};
    int tmo_set[7]   = '{2, 1, 3, 0, 65535, 1, 4};
    int batch_set[7] = '{16, 1, 31, 0, 16, 8, 5};
    stim_row_t r;

    in_ch.valid = 1'b0;
    in_ch.action = ACT_TICK;
    in_ch.sock_index = '0;
    in_ch.kind = KIND_NONE;
    in_ch.tx_seq = '0;
    in_ch.rx_seq = '0;
    m_retry_limit = 8'd3;
    m_timeout = 16'd1000;
    m_batch = 5'd16;
    m_now = '0;
    for (int s = 0; s < SOCKETS; s++) begin
      m_armed[s] = 1'b0; m_kind[s] = KIND_NONE; m_retries[s] = '0;
      m_deadline[s] = '0; m_tx[s] = '0; m_rx[s] = '0;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: retry_limit 1, timeout 2
    configure(1, 2, 16);
    add_row(ACT_ARM, 6'd0, KIND_SYN, 32'h0, 32'hFFFF_FFFF);
    add_row(ACT_ARM, 6'd63, KIND_FIN, 32'hFFFF_FFFF, 32'h0);
    add_row(ACT_ARM, 6'd5, KIND_SYNACK, 32'h1, 32'h2);
    add_row(ACT_ARM, 6'd7, KIND_NONE, 32'h5555_AAAA, 32'hAAAA_5555);
    add_row(ACT_ARM, 6'd9, KIND_SYN, 32'h7, 32'h8);
    add_row(ACT_CANCEL, 6'd9, KIND_NONE, '0, '0);
    add_row(ACT_UNKNOWN, 6'd1, KIND_SYN, 32'h1, 32'h1);
    add_row(ACT_TICK, '0, '0, '0, '0);
    add_row(ACT_TICK, '0, '0, '0, '0);   // deadline equal to now: not expired yet
    add_row(ACT_TICK, '0, '0, '0, '0);   // four expire, one of them silent
    add_row(ACT_ARM, 6'd0, KIND_SYN, 32'd100, 32'd200);   // replace running timer
    add_row(ACT_TICK, '0, '0, '0, '0);
    add_row(ACT_TICK, '0, '0, '0, '0);
    add_row(ACT_TICK, '0, '0, '0, '0);   // retransmit plus two closes
    add_row(ACT_TICK, '0, '0, '0, '0);
    add_row(ACT_TICK, '0, '0, '0, '0);
    add_row(ACT_TICK, '0, '0, '0, '0);   // SYN out of retries
    r = rows[rows.size() - 1];
    r.typed = 1'b1;
    r.want = '{sock: 6'd0, ev: EV_FAILED, seq: 32'h0, ack: 32'h0, flags: 8'h0, last: 1'b1};
    rows[rows.size() - 1] = r;

    foreach (rows[i]) begin
      int before_cnt;
      before_cnt = pending_events.size();
      send_item(rows[i].act, rows[i].idx, rows[i].knd, rows[i].tx, rows[i].rx);
      // typed rows cause a single result; put the hand-written one in its place
      if (rows[i].typed && pending_events.size() == before_cnt + 1)
        pending_events[pending_events.size() - 1] = rows[i].want;
    end
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      configure(retry_set[p], tmo_set[p], batch_set[p]);
      if (p == 5) begin
        // hold the result side off while expiries pile up
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        for (int s = 0; s < 20; s++)
          send_item(ACT_ARM, 6'(s), 2'($urandom_range(1, 3)), $urandom, $urandom);
        repeat (6) send_item(ACT_TICK, '0, '0, $urandom, $urandom);
      end
      repeat (22) random_item();
      if (p == 2) begin
        // pause offering items until every result is back
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_events.size() != 0) @(posedge clk);
        repeat (10) random_item();
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/tcrt_pkg.sv
rtl/tcrt_if.sv
rtl/tcp_control_retransmit_timer.sv
rtl/tcrt_checker.sv
tb/sv/tb_tcp_control_retransmit_timer.sv
